// ----- src/fcba_pkg.sv -----
package fcba_pkg;

	// Table entry codes
	localparam logic [15:0] LINK_FREE = 16'h0000;
	localparam logic [15:0] LINK_EOC  = 16'hFFFF;

	// Request kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_NEXT  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// Register indexes (byte address bit 2)
	localparam logic REG_BLOCK_SIZE    = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic clr_init;
		logic clr_step;
		logic scan;
		logic tail;
		logic walk_rd;
		logic walk_ev;
		logic next_rd;
		logic next_ev;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [1:0] kind;
		logic       clr_last;
		logic       scan_done;
		logic       idx_special;
		logic       idx_oor;
		logic       walk_stop;
		logic       rd_free;
	} sts_t;

endpackage

// ----- src/fcba_ram.sv -----
module fcba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/fcba_ctrl.sv -----
module fcba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fmt,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output fcba_pkg::cmd_t cmd,
	input  fcba_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		CLR_INIT,
		CLEAR,
		IDLE,
		DISPATCH,
		SCAN,
		TAIL,
		WALK_RD,
		WALK_EV,
		NEXT_RD,
		NEXT_EV,
		FIN
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CLR_INIT: state_d = CLEAR;
			CLEAR: begin
				if (sts.clr_last) state_d = IDLE;
			end
			IDLE: begin
				if (s_tvalid) state_d = DISPATCH;
			end
			DISPATCH: begin
				case (sts.kind)
					fcba_pkg::KIND_ALLOC: state_d = SCAN;
					fcba_pkg::KIND_FREE: begin
						if (sts.idx_special || sts.idx_oor) state_d = FIN;
						else state_d = WALK_RD;
					end
					fcba_pkg::KIND_NEXT: begin
						if (sts.idx_oor) state_d = FIN;
						else state_d = NEXT_RD;
					end
					default: state_d = FIN;
				endcase
			end
			SCAN: begin
				if (sts.scan_done) state_d = TAIL;
			end
			TAIL: state_d = FIN;
			WALK_RD: begin
				if (sts.walk_stop) state_d = FIN;
				else state_d = WALK_EV;
			end
			WALK_EV: begin
				if (sts.rd_free) state_d = FIN;
				else state_d = WALK_RD;
			end
			NEXT_RD: state_d = NEXT_EV;
			NEXT_EV: state_d = FIN;
			FIN: begin
				if (!m_tvalid_q || m_tready) state_d = IDLE;
			end
			default: state_d = CLR_INIT;
		endcase
		if (fmt) state_d = CLR_INIT;
	end

	// Decode commands from the state; hold off requests while a reformat is pending
	always_comb begin
		cmd = '0;
		cmd.load     = (state_q == IDLE) && !fmt && s_tvalid;
		cmd.clr_init = (state_q == CLR_INIT);
		cmd.clr_step = (state_q == CLEAR);
		cmd.scan     = (state_q == SCAN);
		cmd.tail     = (state_q == TAIL);
		cmd.walk_rd  = (state_q == WALK_RD) && !sts.walk_stop;
		cmd.walk_ev  = (state_q == WALK_EV);
		cmd.next_rd  = (state_q == NEXT_RD);
		cmd.next_ev  = (state_q == NEXT_EV);
		cmd.out_load = (state_q == FIN) && (!m_tvalid_q || m_tready);
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CLR_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == IDLE) && !fmt;
	assign m_tvalid = m_tvalid_q;

endmodule

// ----- src/fcba_dp.sv -----
module fcba_dp #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fcba_pkg::cmd_t cmd,
	output fcba_pkg::sts_t sts,
	input  logic [1:0]     in_kind,
	input  logic [31:0]    in_byte_count,
	input  logic [15:0]    in_block_index,
	input  logic [16:0]    unit_bytes,
	input  logic [12:0]    blocks_in_use,
	output logic [1:0]     status,
	output logic [15:0]    block_result,
	output logic [15:0]    blocks_moved,
	output logic [12:0]    free_left
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int RW = AW + 1;

	logic [1:0]    kind_q;
	logic [31:0]   bytes_q;
	logic [15:0]   idx_q;
	logic [15:0]   b_q;
	logic [RW-1:0] rd_q;
	logic          sc_valid_s1;
	logic [AW-1:0] sc_addr_s1;
	logic [12:0]   got_q;
	logic [33:0]   acc_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] prev_q;
	logic [AW-1:0] clr_q;
	logic [12:0]   ft_q;
	logic [15:0]   next_q;
	logic [1:0]    status_q;
	logic [15:0]   block_q;
	logic [15:0]   moved_q;
	logic [12:0]   free_q;

	logic [16:0]   bs_eff;
	logic [16:0]   n_ext;
	logic          need_more;
	logic          rd_live;
	logic          claim;
	logic          release_blk;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	logic [1:0]    res_status;
	logic [15:0]   res_block;
	logic [15:0]   res_moved;

	// Size and scan conditions
	assign bs_eff      = (unit_bytes == 17'd0) ? 17'd1 : unit_bytes;
	assign n_ext       = 17'(blocks_in_use);
	assign need_more   = (got_q == 13'd0) || (acc_q < 34'(bytes_q));
	assign rd_live     = 17'(rd_q) < n_ext;
	assign claim       = cmd.scan && sc_valid_s1 && need_more && (ram_rdata == fcba_pkg::LINK_FREE);
	assign release_blk = cmd.walk_ev && (ram_rdata != fcba_pkg::LINK_FREE);

	// Report to the controller
	always_comb begin
		sts.kind        = kind_q;
		sts.clr_last    = 17'(clr_q) == (n_ext - 17'd1);
		sts.scan_done   = !need_more || (!rd_live && !sc_valid_s1);
		sts.idx_special = (idx_q == 16'd0) || (idx_q == fcba_pkg::LINK_EOC);
		sts.idx_oor     = 17'(idx_q) >= n_ext;
		sts.walk_stop   = (b_q == 16'd0) || (17'(b_q) >= n_ext);
		sts.rd_free     = (ram_rdata == fcba_pkg::LINK_FREE);
	end

	// Select the table write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = prev_q;
		ram_wdata = fcba_pkg::LINK_FREE;
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (claim && (got_q != 13'd0)) begin
			ram_we    = 1'b1;
			ram_wdata = 16'(sc_addr_s1);
		end else if (cmd.tail && (got_q != 13'd0)) begin
			ram_we    = 1'b1;
			ram_wdata = fcba_pkg::LINK_EOC;
		end else if (release_blk) begin
			ram_we    = 1'b1;
			ram_waddr = b_q[AW-1:0];
		end
	end

	// Select the table read
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_q[AW-1:0];
		if (cmd.scan && rd_live) begin
			ram_re = 1'b1;
		end else if (cmd.walk_rd) begin
			ram_re    = 1'b1;
			ram_raddr = b_q[AW-1:0];
		end else if (cmd.next_rd) begin
			ram_re    = 1'b1;
			ram_raddr = idx_q[AW-1:0];
		end
	end

	fcba_ram #(
		.WIDTH(16),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Form the result of the finished request
	always_comb begin
		res_status = fcba_pkg::ST_OK;
		res_block  = 16'd0;
		res_moved  = 16'd0;
		case (kind_q)
			fcba_pkg::KIND_ALLOC: begin
				res_status = need_more ? fcba_pkg::ST_NOSPACE : fcba_pkg::ST_OK;
				res_block  = 16'(start_q);
				res_moved  = 16'(got_q);
			end
			fcba_pkg::KIND_FREE: begin
				if (sts.idx_special) res_status = fcba_pkg::ST_OK;
				else if (sts.idx_oor) res_status = fcba_pkg::ST_RANGE;
				else res_moved = 16'(got_q);
			end
			fcba_pkg::KIND_NEXT: begin
				if (sts.idx_oor) res_status = fcba_pkg::ST_RANGE;
				else res_block = next_q;
			end
			default: res_status = fcba_pkg::ST_OK;
		endcase
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_valid_s1 <= 1'b0;
			clr_q       <= '0;
			ft_q        <= 13'd0;
		end else begin
			sc_valid_s1 <= cmd.scan && rd_live;
			if (cmd.clr_init) clr_q <= '0;
			else if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.clr_init) ft_q <= blocks_in_use - 13'd1;
			else if (claim && (ft_q != 13'd0)) ft_q <= ft_q - 13'd1;
			else if (release_blk) ft_q <= ft_q + 13'd1;
		end
	end

	// Request and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			bytes_q <= in_byte_count;
			idx_q   <= in_block_index;
			b_q     <= in_block_index;
			rd_q    <= RW'(1);
			got_q   <= 13'd0;
			acc_q   <= 34'd0;
			start_q <= '0;
			prev_q  <= '0;
		end else begin
			// Advance the first-fit scan
			if (cmd.scan && rd_live) rd_q <= rd_q + RW'(1);
			if (claim) begin
				got_q  <= got_q + 13'd1;
				acc_q  <= acc_q + 34'(bs_eff);
				prev_q <= sc_addr_s1;
				if (got_q == 13'd0) start_q <= sc_addr_s1;
			end
			// Step along the chain
			if (release_blk) begin
				got_q <= got_q + 13'd1;
				b_q   <= ram_rdata;
			end
		end
		sc_addr_s1 <= rd_q[AW-1:0];
		if (cmd.next_ev) next_q <= ram_rdata;
		if (cmd.out_load) begin
			status_q <= res_status;
			block_q  <= res_block;
			moved_q  <= res_moved;
			free_q   <= ft_q;
		end
	end

	assign status       = status_q;
	assign block_result = block_q;
	assign blocks_moved = moved_q;
	assign free_left    = free_q;

endmodule

// ----- src/fat_chain_block_allocator.sv -----
// Allocate: dispatch, a first-fit scan of the table, the tail write, then the result.
// Free: dispatch, then a read and a release per block until the walk leaves the chain or
// reads a free entry. Next: dispatch, a table read, then the result. A request settled at
// dispatch (empty or out-of-range start, unused kind) goes straight to the result. One
// request is in work at a time; the next is accepted once its result has been loaded.
// Reset and each blocks_in_use write mark the table free; no request is accepted meanwhile.
module fat_chain_block_allocator #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // byte_count[31:0], block_index[47:32]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status[1:0], block_result[17:2], blocks_moved[33:18],
	                              // free_left[46:34], zero[47]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [12:0] RST_COUNT = (MAX_BLOCKS < 4096) ? 13'(MAX_BLOCKS) : 13'd4096;

	logic [16:0]      bs_q;
	logic [12:0]      n_q;
	logic             fmt_q;
	logic             cfg_wr;
	logic [12:0]      n_raw;
	logic [12:0]      n_clamped;
	fcba_pkg::cmd_t   cmd;
	fcba_pkg::sts_t   sts;
	logic [1:0]       status;
	logic [15:0]      block_result;
	logic [15:0]      blocks_moved;
	logic [12:0]      free_left;

	// Clamp the managed count to 2..MAX_BLOCKS
	assign n_raw = pwdata[12:0];
	always_comb begin
		if (n_raw < 13'd2) n_clamped = 13'd2;
		else if (17'(n_raw) > 17'(MAX_BLOCKS)) n_clamped = 13'(MAX_BLOCKS);
		else n_clamped = n_raw;
	end

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// Hold configuration registers; a count write triggers a reformat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q  <= 17'd1024;
			n_q   <= RST_COUNT;
			fmt_q <= 1'b0;
		end else begin
			fmt_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[2])
					fcba_pkg::REG_BLOCK_SIZE: bs_q <= pwdata[16:0];
					fcba_pkg::REG_BLOCKS_IN_USE: begin
						n_q   <= n_clamped;
						fmt_q <= 1'b1;
					end
					default: bs_q <= bs_q;
				endcase
			end
		end
	end

	// Read back
	assign prdata = (paddr[2] == fcba_pkg::REG_BLOCKS_IN_USE) ? 32'(n_q) : 32'(bs_q);

	fcba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fmt     (fmt_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	fcba_dp #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_kind       (s_tuser),
		.in_byte_count (s_tdata[31:0]),
		.in_block_index(s_tdata[47:32]),
		.unit_bytes    (bs_q),
		.blocks_in_use (n_q),
		.status        (status),
		.block_result  (block_result),
		.blocks_moved  (blocks_moved),
		.free_left     (free_left)
	);

	assign m_tdata = {1'b0, free_left, blocks_moved, block_result, status};

endmodule
